/* hdl/q2rv_pkg.sv */
// Shared types, widths and the CORDIC arctangent table for the
// quaternion to rotation vector unit. No dependencies.
package q2rv_pkg;

   localparam int SQRT_STEPS   = 32;
   localparam int CORDIC_STEPS = 24;
   localparam int QUO_BITS     = 17;
   localparam int LIMIT_WIDTH  = 29;
   localparam int RAD_W        = 64;
   localparam int CX_W         = 36;
   localparam int ANG_W        = 27;
   localparam int REM_W        = 49;

   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 29'd2684;

   typedef logic signed [15:0] quat_type;

   typedef struct packed {
      quat_type         w;
      quat_type [2:0]   v;
      logic             full;
      logic [31:0]      sine;
      logic [31:0]      tx;
      logic [31:0]      ty;
      logic [31:0]      tz;
      logic [31:0]      scale;
   } item_type;

   typedef struct packed {
      logic                neg;
      logic                ovf;
      logic [REM_W-1:0]    rem;
      logic [QUO_BITS-1:0] quo;
   } lane_type;

   // atan(2^-i) in Q.24
   function automatic logic signed [ANG_W-1:0] atan_entry(input int step);
      logic signed [ANG_W-1:0] a;
      case (step)
         0:  a = 27'sd13176795;
         1:  a = 27'sd7778716;
         2:  a = 27'sd4110060;
         3:  a = 27'sd2086331;
         4:  a = 27'sd1047214;
         5:  a = 27'sd524117;
         6:  a = 27'sd262123;
         7:  a = 27'sd131069;
         8:  a = 27'sd65536;
         9:  a = 27'sd32768;
         10: a = 27'sd16384;
         11: a = 27'sd8192;
         12: a = 27'sd4096;
         13: a = 27'sd2048;
         14: a = 27'sd1024;
         15: a = 27'sd512;
         16: a = 27'sd256;
         17: a = 27'sd128;
         18: a = 27'sd64;
         19: a = 27'sd32;
         20: a = 27'sd16;
         21: a = 27'sd8;
         22: a = 27'sd4;
         23: a = 27'sd2;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

/* hdl/q2rv_sqrt_cell.sv */
// One digit of the integer square root chain (one result bit per cell).
// Depends on q2rv_pkg.
module q2rv_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  q2rv_pkg::item_type         in_item,
   input  logic [q2rv_pkg::RAD_W-1:0] in_rad,
   input  logic [q2rv_pkg::RAD_W-1:0] in_root,
   output logic                       out_valid,
   output q2rv_pkg::item_type         out_item,
   output logic [q2rv_pkg::RAD_W-1:0] out_rad,
   output logic [q2rv_pkg::RAD_W-1:0] out_root
);

   localparam logic [q2rv_pkg::RAD_W-1:0] BIT_VAL =
      q2rv_pkg::RAD_W'(1) << (q2rv_pkg::RAD_W - 2 - 2 * STEP);

   logic                       valid_ff;
   q2rv_pkg::item_type         item_ff;
   logic [q2rv_pkg::RAD_W-1:0] rad_ff, rad_in;
   logic [q2rv_pkg::RAD_W-1:0] root_ff, root_in;
   logic [q2rv_pkg::RAD_W-1:0] trial;

   always_comb begin
      trial = in_root + BIT_VAL;
      if (in_rad >= trial) begin
         rad_in  = in_rad - trial;
         root_in = (in_root >> 1) + BIT_VAL;
      end else begin
         rad_in  = in_rad;
         root_in = in_root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= in_item;
         rad_ff  <= rad_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_rad   = rad_ff;
   assign out_root  = root_ff;

endmodule

/* hdl/q2rv_cordic_cell.sv */
// One vectoring iteration of the CORDIC atan2 chain.
// Depends on q2rv_pkg.
module q2rv_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  q2rv_pkg::item_type                in_item,
   input  logic signed [q2rv_pkg::CX_W-1:0]  in_x,
   input  logic signed [q2rv_pkg::CX_W-1:0]  in_y,
   input  logic signed [q2rv_pkg::ANG_W-1:0] in_z,
   output logic                              out_valid,
   output q2rv_pkg::item_type                out_item,
   output logic signed [q2rv_pkg::CX_W-1:0]  out_x,
   output logic signed [q2rv_pkg::CX_W-1:0]  out_y,
   output logic signed [q2rv_pkg::ANG_W-1:0] out_z
);

   localparam logic signed [q2rv_pkg::ANG_W-1:0] ANGLE = q2rv_pkg::atan_entry(STEP);

   logic                              valid_ff;
   q2rv_pkg::item_type                item_ff;
   logic signed [q2rv_pkg::CX_W-1:0]  x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [q2rv_pkg::ANG_W-1:0] z_ff, z_in;
   logic                              pos;

   always_comb begin
      dx  = in_y >>> STEP;
      dy  = in_x >>> STEP;
      pos = !in_y[q2rv_pkg::CX_W-1] && (in_y != '0);
      if (pos) begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ANGLE;
      end else begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff <= in_item;
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

/* hdl/q2rv_div_cell.sv */
// One quotient bit of the three-lane restoring divider chain (divisor is the sine).
// Depends on q2rv_pkg.
module q2rv_div_cell #(
   parameter int STEP = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  q2rv_pkg::item_type       in_item,
   input  q2rv_pkg::lane_type [2:0] in_lanes,
   output logic                     out_valid,
   output q2rv_pkg::item_type       out_item,
   output q2rv_pkg::lane_type [2:0] out_lanes
);

   localparam int SHIFT = q2rv_pkg::QUO_BITS - 1 - STEP;

   logic                         valid_ff;
   q2rv_pkg::item_type           item_ff;
   q2rv_pkg::lane_type [2:0]     lanes_ff, lanes_in;
   logic [q2rv_pkg::REM_W-1:0]   sub;

   always_comb begin
      sub = q2rv_pkg::REM_W'(in_item.sine) << SHIFT;
      for (int i = 0; i < 3; i++) begin
         lanes_in[i] = in_lanes[i];
         if (in_lanes[i].rem >= sub) begin
            lanes_in[i].rem = in_lanes[i].rem - sub;
            lanes_in[i].quo = {in_lanes[i].quo[q2rv_pkg::QUO_BITS-2:0], 1'b1};
         end else begin
            lanes_in[i].quo = {in_lanes[i].quo[q2rv_pkg::QUO_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         item_ff  <= in_item;
         lanes_ff <= lanes_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_lanes = lanes_ff;

endmodule

/* hdl/quaternion_to_rotation_vector_unit.sv */
// Top level: quaternion to rotation vector with translation and scale pass-through.
// Depends on q2rv_pkg, q2rv_sqrt_cell, q2rv_cordic_cell, q2rv_div_cell.
//
// Takes one word per cycle while req_stall is low and returns one word per input, in
// order. There are 79 register stages from the accepting edge to rsp_valid: input,
// square, norm/compare stages, 32 square-root cells, 24 CORDIC cells, multiply and
// round-offset stages, 17 divider cells and the output register. The whole chain
// moves together and halts only when its last cell holds a word while the output
// register is full and stalled; req_stall follows that condition combinationally.
module quaternion_to_rotation_vector_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [15:0]               req_quat_w,
   input  logic signed [15:0]               req_quat_x,
   input  logic signed [15:0]               req_quat_y,
   input  logic signed [15:0]               req_quat_z,
   input  logic signed [31:0]               req_trans_x_in,
   input  logic signed [31:0]               req_trans_y_in,
   input  logic signed [31:0]               req_trans_z_in,
   input  logic [31:0]                      req_scale_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [15:0]               rsp_rot_x,
   output logic signed [15:0]               rsp_rot_y,
   output logic signed [15:0]               rsp_rot_z,
   output logic signed [31:0]               rsp_trans_x_out,
   output logic signed [31:0]               rsp_trans_y_out,
   output logic signed [31:0]               rsp_trans_z_out,
   output logic [31:0]                      rsp_scale_out,
   input  logic                             csr_wr_en,
   input  logic [q2rv_pkg::LIMIT_WIDTH-1:0] csr_wr_data
);

   localparam int SQ = q2rv_pkg::SQRT_STEPS;
   localparam int CS = q2rv_pkg::CORDIC_STEPS;
   localparam int DS = q2rv_pkg::QUO_BITS;

   logic                             advance;
   logic [q2rv_pkg::LIMIT_WIDTH-1:0] limit_ff;

   // front stages
   logic                 a_valid_ff, b_valid_ff, c_valid_ff;
   q2rv_pkg::item_type   a_item_ff, a_item_in, b_item_ff, c_item_ff, c_item_in;
   logic [30:0]          b_sq_ff [3];
   logic [30:0]          b_sq_in [3];
   logic [31:0]          c_n2_ff, c_n2_in;

   // chains
   logic                             sq_valid [SQ+1];
   q2rv_pkg::item_type               sq_item  [SQ+1];
   logic [q2rv_pkg::RAD_W-1:0]       sq_rad   [SQ+1];
   logic [q2rv_pkg::RAD_W-1:0]       sq_root  [SQ+1];
   logic                             cr_valid [CS+1];
   q2rv_pkg::item_type               cr_item  [CS+1];
   logic signed [q2rv_pkg::CX_W-1:0] cr_x     [CS+1];
   logic signed [q2rv_pkg::CX_W-1:0] cr_y     [CS+1];
   logic signed [q2rv_pkg::ANG_W-1:0] cr_z    [CS+1];
   logic                             dv_valid [DS+1];
   q2rv_pkg::item_type               dv_item  [DS+1];
   q2rv_pkg::lane_type [2:0]         dv_lanes [DS+1];

   // multiply and offset stages
   logic                     m_valid_ff, p_valid_ff;
   q2rv_pkg::item_type       m_item_ff, p_item_ff;
   q2rv_pkg::lane_type [2:0] m_lanes_ff, m_lanes_in, p_lanes_ff, p_lanes_in;
   logic signed [42:0]       prod [3];
   logic [42:0]              pmag [3];
   logic [q2rv_pkg::REM_W-1:0] ovf_lim;

   // output
   logic                 rsp_valid_ff, rsp_valid_in;
   q2rv_pkg::item_type   rsp_item_ff;
   logic signed [15:0]   rot_ff [3];
   logic signed [15:0]   rot_in [3];
   logic                 last_valid;

   assign last_valid = dv_valid[DS];
   assign advance    = !last_valid || !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= q2rv_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // stage A: capture word
   always_comb begin
      a_item_in       = '0;
      a_item_in.w     = req_quat_w;
      a_item_in.v[0]  = req_quat_x;
      a_item_in.v[1]  = req_quat_y;
      a_item_in.v[2]  = req_quat_z;
      a_item_in.tx    = req_trans_x_in;
      a_item_in.ty    = req_trans_y_in;
      a_item_in.tz    = req_trans_z_in;
      a_item_in.scale = req_scale_in;
   end

   // stage B: squares
   always_comb begin
      logic signed [31:0] p;
      for (int i = 0; i < 3; i++) begin
         p          = 32'(a_item_ff.v[i]) * 32'(a_item_ff.v[i]);
         b_sq_in[i] = p[30:0];
      end
   end

   // stage C: squared norm and threshold
   always_comb begin
      c_n2_in        = 32'(b_sq_ff[0]) + 32'(b_sq_ff[1]) + 32'(b_sq_ff[2]);
      c_item_in      = b_item_ff;
      c_item_in.full = c_n2_in > 32'(limit_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_item_ff <= a_item_in;
         b_item_ff <= a_item_ff;
         b_sq_ff   <= b_sq_in;
         c_item_ff <= c_item_in;
         c_n2_ff   <= c_n2_in;
      end
   end

   // square root chain
   assign sq_valid[0] = c_valid_ff;
   assign sq_item[0]  = c_item_ff;
   assign sq_rad[0]   = {c_n2_ff, 32'd0};
   assign sq_root[0]  = '0;

   for (genvar k = 0; k < SQ; k++) begin : g_sqrt
      q2rv_sqrt_cell #(.STEP(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (sq_valid[k]),
         .in_item   (sq_item[k]),
         .in_rad    (sq_rad[k]),
         .in_root   (sq_root[k]),
         .out_valid (sq_valid[k+1]),
         .out_item  (sq_item[k+1]),
         .out_rad   (sq_rad[k+1]),
         .out_root  (sq_root[k+1])
      );
   end

   // CORDIC chain: x = |w| * 2^16, y = sine
   always_comb begin
      logic signed [16:0] aw;
      cr_item[0]      = sq_item[SQ];
      cr_item[0].sine = sq_root[SQ][31:0];
      aw              = sq_item[SQ].w[15] ? -17'(sq_item[SQ].w) : 17'(sq_item[SQ].w);
      cr_x[0]         = q2rv_pkg::CX_W'(aw) <<< 16;
      cr_y[0]         = q2rv_pkg::CX_W'({1'b0, sq_root[SQ][31:0]});
      cr_z[0]         = '0;
   end
   assign cr_valid[0] = sq_valid[SQ];

   for (genvar k = 0; k < CS; k++) begin : g_cordic
      q2rv_cordic_cell #(.STEP(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (cr_valid[k]),
         .in_item   (cr_item[k]),
         .in_x      (cr_x[k]),
         .in_y      (cr_y[k]),
         .in_z      (cr_z[k]),
         .out_valid (cr_valid[k+1]),
         .out_item  (cr_item[k+1]),
         .out_x     (cr_x[k+1]),
         .out_y     (cr_y[k+1]),
         .out_z     (cr_z[k+1])
      );
   end

   // stage M: q * angle, magnitude times 64, sign includes the sign of w
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[i]           = 43'(cr_item[CS].v[i]) * 43'(cr_z[CS]);
         pmag[i]           = prod[i][42] ? 43'(-prod[i]) : 43'(prod[i]);
         m_lanes_in[i].neg = prod[i][42] ^ cr_item[CS].w[15];
         m_lanes_in[i].ovf = 1'b0;
         m_lanes_in[i].rem = q2rv_pkg::REM_W'(pmag[i]) << 6;
         m_lanes_in[i].quo = '0;
      end
   end

   // stage P: add half divisor for rounding, flag quotients past 17 bits
   always_comb begin
      ovf_lim = q2rv_pkg::REM_W'(m_item_ff.sine) << DS;
      for (int i = 0; i < 3; i++) begin
         p_lanes_in[i]     = m_lanes_ff[i];
         p_lanes_in[i].rem = m_lanes_ff[i].rem + q2rv_pkg::REM_W'(m_item_ff.sine >> 1);
         p_lanes_in[i].ovf = p_lanes_in[i].rem >= ovf_lim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff <= cr_valid[CS];
         p_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_item_ff  <= cr_item[CS];
         m_lanes_ff <= m_lanes_in;
         p_item_ff  <= m_item_ff;
         p_lanes_ff <= p_lanes_in;
      end
   end

   // divider chain
   assign dv_valid[0] = p_valid_ff;
   assign dv_item[0]  = p_item_ff;
   assign dv_lanes[0] = p_lanes_ff;

   for (genvar k = 0; k < DS; k++) begin : g_div
      q2rv_div_cell #(.STEP(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (dv_valid[k]),
         .in_item   (dv_item[k]),
         .in_lanes  (dv_lanes[k]),
         .out_valid (dv_valid[k+1]),
         .out_item  (dv_item[k+1]),
         .out_lanes (dv_lanes[k+1])
      );
   end

   // saturate and pick path
   always_comb begin
      q2rv_pkg::lane_type ln;
      for (int i = 0; i < 3; i++) begin
         ln = dv_lanes[DS][i];
         if (!dv_item[DS].full) begin
            rot_in[i] = dv_item[DS].v[i];
         end else if (ln.neg) begin
            if (ln.ovf || ln.quo > 17'd32768) begin
               rot_in[i] = 16'sh8000;
            end else begin
               rot_in[i] = 16'(-ln.quo);
            end
         end else begin
            if (ln.ovf || ln.quo > 17'd32767) begin
               rot_in[i] = 16'sh7fff;
            end else begin
               rot_in[i] = 16'(ln.quo);
            end
         end
      end
   end

   always_comb begin
      if (last_valid && advance) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last_valid && advance) begin
         rsp_item_ff <= dv_item[DS];
         rot_ff      <= rot_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rot_x       = rot_ff[0];
   assign rsp_rot_y       = rot_ff[1];
   assign rsp_rot_z       = rot_ff[2];
   assign rsp_trans_x_out = rsp_item_ff.tx;
   assign rsp_trans_y_out = rsp_item_ff.ty;
   assign rsp_trans_z_out = rsp_item_ff.tz;
   assign rsp_scale_out   = rsp_item_ff.scale;

`ifndef SYNTHESIS
   a_no_stall_when_tail_empty: assert property (@(posedge clock) disable iff (reset)
      !last_valid |-> !req_stall)
      else $error("input stalled with empty chain tail");

   a_sine_nonzero_on_full_path: assert property (@(posedge clock) disable iff (reset)
      cr_valid[0] && cr_item[0].full |-> cr_item[0].sine != 32'd0)
      else $error("full path entered CORDIC with zero sine");

   a_root_fits: assert property (@(posedge clock) disable iff (reset)
      sq_valid[SQ] |-> sq_root[SQ][63:32] == 32'd0)
      else $error("square root result wider than 32 bits");

   a_stall_holds_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rot_ff[0]))
      else $error("pending result lost under stall");
`endif

endmodule

/* test/testbench.sv */
// Self-checking testbench for quaternion_to_rotation_vector_unit: drives random and
// directed quaternion words, predicts the rotation vector and checks every result word.
// Depends on q2rv_pkg and the unit's RTL.
`timescale 1ns / 1ps

class pose_scoreboard;
   typedef struct {
      logic signed [15:0] rx, ry, rz;
      logic [31:0]        tx, ty, tz, sc;
   } pose_type;

   pose_type   pending[$];
   logic [28:0] angle_limit;
   int         errors;

   function new();
      angle_limit = q2rv_pkg::LIMIT_RESET;
      errors = 0;
   endfunction

   function longint shift_floor(longint v, int k);
      if (v >= 0) return v >>> k;
      return -((-v + ((64'sd1 <<< k) - 1)) >>> k);
   endfunction

   function longint round_div(longint num, longint den);
      longint m;
      m = num < 0 ? -num : num;
      m = (m + den / 2) / den;
      return num < 0 ? -m : m;
   endfunction

   function logic signed [15:0] clip(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function longint root64(logic [63:0] n);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function longint half_angle(longint x, longint y);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < q2rv_pkg::CORDIC_STEPS; i++) begin
         dx = shift_floor(y, i);
         dy = shift_floor(x, i);
         if (y > 0) begin
            x += dx; y -= dy; z += longint'(q2rv_pkg::atan_entry(i));
         end else begin
            x -= dx; y += dy; z -= longint'(q2rv_pkg::atan_entry(i));
         end
      end
      return z;
   endfunction

   function void note_request(logic signed [15:0] w, x, y, z,
                              logic [31:0] tx, ty, tz, sc);
      longint q[3], s, h, aw, n2;
      pose_type p;
      logic signed [15:0] r[3];
      q[0] = x; q[1] = y; q[2] = z;
      n2 = q[0]*q[0] + q[1]*q[1] + q[2]*q[2];
      if (n2 > longint'(angle_limit)) begin
         s = root64(64'(n2) << 32);
         aw = w < 0 ? -longint'(w) : longint'(w);
         h = half_angle(aw * 65536, s);
         if (w < 0) h = -h;
         for (int i = 0; i < 3; i++) r[i] = clip(round_div(q[i] * h * 64, s));
      end else begin
         for (int i = 0; i < 3; i++) r[i] = clip(round_div(q[i] * 16384, 16384));
      end
      p.rx = r[0]; p.ry = r[1]; p.rz = r[2];
      p.tx = tx; p.ty = ty; p.tz = tz; p.sc = sc;
      pending.push_back(p);
   endfunction

   function void check_result(pose_type got);
      pose_type e;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected result word rot=%0d,%0d,%0d",
                                    got.rx, got.ry, got.rz);
         return;
      end
      e = pending.pop_front();
      if (got.rx !== e.rx || got.ry !== e.ry || got.rz !== e.rz || got.tx !== e.tx ||
          got.ty !== e.ty || got.tz !== e.tz || got.sc !== e.sc) begin
         errors++;
         if (errors <= 10)
            $display("rot exp %0d,%0d,%0d got %0d,%0d,%0d; pass exp %h %h %h %h got %h %h %h %h",
                     e.rx, e.ry, e.rz, got.rx, got.ry, got.rz, e.tx, e.ty, e.tz, e.sc,
                     got.tx, got.ty, got.tz, got.sc);
      end
   endfunction
endclass

module testbench;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0, csr_wr_en = 0;
   logic req_stall, rsp_valid;
   logic signed [15:0] req_quat_w = 0, req_quat_x = 0, req_quat_y = 0, req_quat_z = 0;
   logic signed [31:0] req_trans_x_in = 0, req_trans_y_in = 0, req_trans_z_in = 0;
   logic [31:0] req_scale_in = 0;
   logic signed [15:0] rsp_rot_x, rsp_rot_y, rsp_rot_z;
   logic signed [31:0] rsp_trans_x_out, rsp_trans_y_out, rsp_trans_z_out;
   logic [31:0] rsp_scale_out;
   logic [q2rv_pkg::LIMIT_WIDTH-1:0] csr_wr_data = 0;

   int idle_pct = 0, stall_pct = 0;
   pose_scoreboard board;

   quaternion_to_rotation_vector_unit uut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result('{rsp_rot_x, rsp_rot_y, rsp_rot_z, rsp_trans_x_out,
                              rsp_trans_y_out, rsp_trans_z_out, rsp_scale_out});
   end

   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   task automatic send_word(logic signed [15:0] w, x, y, z);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_quat_w <= w; req_quat_x <= x; req_quat_y <= y; req_quat_z <= z;
      req_trans_x_in <= $urandom; req_trans_y_in <= $urandom;
      req_trans_z_in <= $urandom; req_scale_in <= $urandom;
      do @(posedge clock); while (req_stall);
      board.note_request(w, x, y, z, req_trans_x_in, req_trans_y_in,
                         req_trans_z_in, req_scale_in);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (90) @(negedge clock);
   endtask

   task automatic write_limit(logic [q2rv_pkg::LIMIT_WIDTH-1:0] v);
      csr_wr_en <= 1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 0;
      board.angle_limit = v;
   endtask

   function automatic logic signed [15:0] rand_comp(int mag);
      return 16'($signed($urandom_range(2 * mag)) - mag);
   endfunction

   task automatic random_words(int n);
      int kind, m;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(9);
         m = kind < 3 ? 16 : (kind < 5 ? 200 : 16384);
         if (kind == 9)
            send_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         else
            send_word(rand_comp(16384), rand_comp(m), rand_comp(m), rand_comp(m));
      end
   endtask

   initial begin
      board = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_word(16384, 0, 0, 0);
      send_word(0, 16384, 0, 0);
      send_word(0, 0, -16384, 0);
      send_word(-16384, 0, 0, 16384);
      send_word(-1, 16384, 16384, 16384);
      send_word(-16384, 1, 0, 0);
      send_word(16384, -16384, -16384, -16384);
      send_word(-32768, -32768, -32768, -32768);
      send_word(32767, 32767, 32767, 32767);
      send_word(11585, 11585, 0, 0);
      send_word(-11585, 0, 11585, 0);
      send_word(16380, 51, 0, 0);
      send_word(16380, 52, 0, 0);
      send_word(0, 0, 0, 1);
      drain();
      write_limit('0);
      send_word(16384, 0, 0, 1);
      send_word(-16384, -1, 0, 0);
      send_word(0, 0, 0, 0);
      drain();
      write_limit(29'h1fffffff);
      send_word(0, 16384, 16384, 16384);
      send_word(-32768, -32768, -32768, -32768);
      drain();
      write_limit(29'd268435456);
      random_words(100);
      drain();
      write_limit(q2rv_pkg::LIMIT_RESET);
      idle_pct = 0;   stall_pct = 0;  random_words(400);
      idle_pct = 49;  stall_pct = 0;  random_words(300);
      drain();
      write_limit('0);
      idle_pct = 0;   stall_pct = 49; random_words(300);
      idle_pct = 10;  stall_pct = 10; random_words(300);
      drain();
      write_limit(29'($urandom_range(20000)));
      idle_pct = 0;   stall_pct = 0;  random_words(200);
      drain();
      if (board.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end
endmodule

/* filelist.f */
hdl/q2rv_pkg.sv
hdl/q2rv_sqrt_cell.sv
hdl/q2rv_cordic_cell.sv
hdl/q2rv_div_cell.sv
hdl/quaternion_to_rotation_vector_unit.sv
test/testbench.sv
